### rtl/tensor_transpose_address_gen_core_macros.svh
// Assertion macros for the tensor transpose address generator checker
`ifndef TENSOR_TRANSPOSE_ADDRESS_GEN_CORE_MACROS_SVH
`define TENSOR_TRANSPOSE_ADDRESS_GEN_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define TTAG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttag assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define TTAG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttag assertion failed");

`endif

### rtl/ttag_pkg.sv
// Package: widths, register indexes and helpers for the transpose address generator
package ttag_pkg;

  localparam int MAX_DIMS   = 5;
  localparam int ELEM_BITS  = 32;
  localparam int INDEX_BITS = 24;
  localparam int SIZE_BITS  = 12;

  localparam int DIM_W  = 3;
  localparam int EXT_W  = SIZE_BITS + 1;
  localparam int PERM_W = MAX_DIMS * DIM_W;
  localparam int ADDR_W = 3;
  localparam int DATA_W = PERM_W;

  typedef logic [DIM_W-1:0]      dim_t;
  typedef logic [EXT_W-1:0]      ext_t;
  typedef logic [SIZE_BITS-1:0]  pos_t;
  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [PERM_W-1:0]     perm_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [DATA_W-1:0]     data_t;
  typedef logic [ELEM_BITS-1:0]  elem_t;

  localparam addr_t CFG_NUM_DIMS = 3'd0;
  localparam addr_t CFG_DIM0     = 3'd1;
  localparam addr_t CFG_DIM4     = 3'd5;
  localparam addr_t CFG_PERM     = 3'd6;

  localparam ext_t EXT_MAX = ext_t'(1) << SIZE_BITS;
  localparam perm_t PERM_RESET = perm_t'(18056);

  function automatic dim_t perm_field(input perm_t perm, input dim_t i);
    perm_field = dim_t'(perm >> (i * DIM_W));
  endfunction

endpackage

### rtl/tensor_transpose_address_gen_core.sv
// Top level: transposed linear index generator for up to five tensor dimensions
//
//  channel | handshake            | beat
//  --------+----------------------+------------------------------------------
//  cfg     | cfg_wr_en            | cfg_addr, cfg_wdata
//  in      | in_valid / in_stall  | elem_value
//  out     | out_valid / out_stall| dest_index, out_value, last, error
//
// One beat per cycle unless stalled: input register, one odometer step, output register.
// A taken beat passes the input register, then the output register, before it shows on out_valid.
// After reset or a listed register write the stride sequencer runs its check, stride, multiply
// and accumulate states, ending early on a bad setup; in_stall stays high meanwhile.
// The sequencer has a 25x13 multiplier for the strides and a 13x24 one for the wrap terms.
// out_stall holds the output register; the input register still takes one beat.
module tensor_transpose_address_gen_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  ttag_pkg::addr_t          cfg_addr,
  input  ttag_pkg::data_t          cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  ttag_pkg::elem_t          elem_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output ttag_pkg::idx_t           dest_index,
  output ttag_pkg::elem_t          out_value,
  output logic                     last,
  output logic                     error
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_STRIDE = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_ACC    = 3'd4;

  localparam int MD = ttag_pkg::MAX_DIMS;
  localparam int PROD_W = ttag_pkg::INDEX_BITS + 1 + ttag_pkg::EXT_W;
  localparam logic [PROD_W-1:0] LIMIT = PROD_W'(1) << ttag_pkg::INDEX_BITS;

  ttag_pkg::dim_t  num_dims;
  ttag_pkg::ext_t  dim_size [MD];
  ttag_pkg::perm_t perm_packed;

  logic [2:0]              state;
  ttag_pkg::dim_t          kcnt;
  logic                    cfg_bad;
  logic [ttag_pkg::INDEX_BITS:0] stride_acc;
  ttag_pkg::idx_t          acc;
  ttag_pkg::idx_t          wrap_prod;
  ttag_pkg::idx_t          dest_stride [MD];
  ttag_pkg::idx_t          step_add [MD];
  ttag_pkg::pos_t          position [MD];
  ttag_pkg::idx_t          dest_offset;

  logic                    s1_valid;
  ttag_pkg::elem_t         s1_value;

  logic                    cfg_hit;
  logic                    adv;
  logic                    chk_bad;
  ttag_pkg::dim_t          str_o;
  ttag_pkg::dim_t          str_p;
  ttag_pkg::ext_t          str_size;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       wprod;

  ttag_pkg::ext_t          pos_inc [MD];
  logic [MD:0]             wrap;
  logic [MD:0]             carry;
  logic                    last_hit;
  ttag_pkg::idx_t          off_add;

  assign cfg_hit  = cfg_wr_en && (cfg_addr <= ttag_pkg::CFG_PERM);
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = (state != ST_IDLE) || (s1_valid && !adv);

  // configuration sanity: dimension count, permutation, extents
  always_comb begin
    chk_bad = (num_dims == '0) || (num_dims > ttag_pkg::dim_t'(MD));
    for (int i = 0; i < MD; i++) begin
      if (ttag_pkg::dim_t'(i) < num_dims) begin
        if (ttag_pkg::perm_field(perm_packed, ttag_pkg::dim_t'(i)) >= num_dims) chk_bad = 1'b1;
        if (dim_size[i] == '0 || dim_size[i] > ttag_pkg::EXT_MAX) chk_bad = 1'b1;
        for (int j = i + 1; j < MD; j++) begin
          if (ttag_pkg::dim_t'(j) < num_dims &&
              ttag_pkg::perm_field(perm_packed, ttag_pkg::dim_t'(i)) ==
              ttag_pkg::perm_field(perm_packed, ttag_pkg::dim_t'(j))) chk_bad = 1'b1;
        end
      end
    end
  end

  assign str_o    = num_dims - 3'd1 - kcnt;
  assign str_p    = ttag_pkg::perm_field(perm_packed, str_o);
  assign str_size = dim_size[str_p];
  assign prod     = PROD_W'(stride_acc) * PROD_W'(str_size);
  assign wprod    = PROD_W'(dim_size[kcnt]) * PROD_W'(dest_stride[kcnt]);

  // odometer carry chain, innermost used dimension first
  always_comb begin
    wrap[MD]  = 1'b0;
    carry[MD] = 1'b0;
    for (int d = MD - 1; d >= 0; d--) begin
      pos_inc[d] = ttag_pkg::ext_t'(position[d]) + ttag_pkg::ext_t'(1);
      wrap[d]    = pos_inc[d] >= dim_size[d];
      carry[d]   = (ttag_pkg::dim_t'(d) < num_dims) &&
                   ((ttag_pkg::dim_t'(d) == num_dims - 3'd1) || (carry[d+1] && wrap[d+1]));
    end
    last_hit = carry[0] && wrap[0];
    off_add  = '0;
    for (int d = 0; d < MD; d++) begin
      if (carry[d] && !wrap[d]) off_add = off_add | step_add[d];
    end
  end

  // registers, stride sequencer and odometer state
  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims    <= ttag_pkg::dim_t'(1);
      perm_packed <= ttag_pkg::PERM_RESET;
      state       <= ST_CHECK;
      kcnt        <= '0;
      cfg_bad     <= 1'b0;
      dest_offset <= '0;
      for (int i = 0; i < MD; i++) begin
        dim_size[i]    <= ttag_pkg::ext_t'(1);
        position[i]    <= '0;
        dest_stride[i] <= '0;
        step_add[i]    <= '0;
      end
    end else if (cfg_hit) begin
      unique case (cfg_addr)
        ttag_pkg::CFG_NUM_DIMS: num_dims <= cfg_wdata[ttag_pkg::DIM_W-1:0];
        ttag_pkg::CFG_PERM:     perm_packed <= cfg_wdata;
        default: dim_size[cfg_addr - ttag_pkg::CFG_DIM0] <= cfg_wdata[ttag_pkg::EXT_W-1:0];
      endcase
      state       <= ST_CHECK;
      dest_offset <= '0;
      for (int i = 0; i < MD; i++) position[i] <= '0;
    end else begin
      unique case (state)
        ST_CHECK: begin
          for (int i = 0; i < MD; i++) begin
            dest_stride[i] <= '0;
            step_add[i]    <= '0;
          end
          cfg_bad    <= chk_bad;
          kcnt       <= '0;
          stride_acc <= (ttag_pkg::INDEX_BITS+1)'(1);
          state      <= chk_bad ? ST_IDLE : ST_STRIDE;
        end
        ST_STRIDE: begin
          stride_acc <= prod[ttag_pkg::INDEX_BITS:0];
          if (prod > LIMIT) begin
            cfg_bad <= 1'b1;
            for (int i = 0; i < MD; i++) dest_stride[i] <= '0;
            state <= ST_IDLE;
          end else begin
            dest_stride[str_p] <= stride_acc[ttag_pkg::INDEX_BITS-1:0];
            if (kcnt == num_dims - 3'd1) begin
              acc   <= '0;
              state <= ST_MUL;
            end else begin
              kcnt <= kcnt + 3'd1;
            end
          end
        end
        ST_MUL: begin
          wrap_prod <= wprod[ttag_pkg::INDEX_BITS-1:0];
          state     <= ST_ACC;
        end
        ST_ACC: begin
          step_add[kcnt] <= dest_stride[kcnt] + acc;
          acc            <= acc + dest_stride[kcnt] - wrap_prod;
          if (kcnt == '0) begin
            state <= ST_IDLE;
          end else begin
            kcnt  <= kcnt - 3'd1;
            state <= ST_MUL;
          end
        end
        default: begin
          if (adv) begin
            if (cfg_bad || last_hit) begin
              dest_offset <= '0;
              for (int i = 0; i < MD; i++) position[i] <= '0;
            end else begin
              dest_offset <= dest_offset + off_add;
              for (int i = 0; i < MD; i++) begin
                if (carry[i] && wrap[i]) position[i] <= '0;
                else if (carry[i]) position[i] <= pos_inc[i][ttag_pkg::SIZE_BITS-1:0];
              end
            end
          end
        end
      endcase
    end
  end

  // beat handshake: input register then output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) s1_valid <= 1'b1;
      else if (adv) s1_valid <= 1'b0;
      if (adv) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_value <= elem_value;
    if (adv) begin
      out_value  <= s1_value;
      dest_index <= cfg_bad ? '0 : dest_offset;
      last       <= !cfg_bad && last_hit;
      error      <= cfg_bad;
    end
  end

endmodule

### rtl/ttag_checker.sv
// Port-level checker for the transpose address generator, bound to the top level
`include "tensor_transpose_address_gen_core_macros.svh"

module ttag_checker (
  input logic             clk,
  input logic             rst,
  input logic             cfg_wr_en,
  input ttag_pkg::addr_t  cfg_addr,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input ttag_pkg::idx_t   dest_index,
  input logic             last,
  input logic             error
);

  // error beats carry index zero and never close a tensor
  `TTAG_ASSERT_IMP(a_err_zero, out_valid && error, dest_index == '0 && !last)

  // a listed register write starts the stride sequencer, so input is held off
  `TTAG_ASSERT_NXT(a_cfg_holds_in, cfg_wr_en && cfg_addr <= ttag_pkg::CFG_PERM, in_stall)

  // stalled result stays put
  `TTAG_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(dest_index) && $stable(last) && $stable(error))

endmodule

bind tensor_transpose_address_gen_core ttag_checker u_ttag_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_wr_en  (cfg_wr_en),
  .cfg_addr   (cfg_addr),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .dest_index (dest_index),
  .last       (last),
  .error      (error)
);
